// ===== sv/tsfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfp_pkg
// shared types and constants of the time-sync frame parser
// ----------------------------------------------------------------------------
package tsfp_pkg;

    localparam int unsigned TSFP_QUEUE_DEPTH = 2;

    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned FRAME_LEN = 9;
    localparam int unsigned COUNT_MAX = 10;
    localparam int unsigned STORE_LO  = 2;     // first stored byte index
    localparam int unsigned STORE_N   = 7;     // bytes 2 to 8 are kept

    localparam logic [7:0] HDR_SYNC = 8'hFF;
    localparam logic [7:0] HDR_ID   = 8'h01;

    localparam logic [11:0] YEAR_BASE  = 12'd2000;
    localparam logic [7:0]  YEAR_SPAN  = 8'd100;
    localparam logic [7:0]  MONTH_END  = 8'd13;
    localparam logic [7:0]  DAY_END    = 8'd32;
    localparam logic [7:0]  HOUR_END   = 8'd24;
    localparam logic [7:0]  MINUTE_END = 8'd60;

    // milliseconds / 1000 as (ms * 67109) >> 26, exact for every 16-bit ms
    localparam logic [16:0] MS_RECIP = 17'd67109;
    localparam int unsigned MS_SHIFT = 26;
    localparam logic [15:0] MS_LIMIT = 16'd60000;   // 60 s and above is out of range

    typedef enum logic [1:0] {
        ST_ACCEPTED   = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_BAD_FIELD  = 2'd3
    } status_t;

    typedef struct packed {
        logic       hdr_bad;
        logic       len_ok;
        logic [7:0] year_raw;
        logic [7:0] month_raw;
        logic [7:0] day_raw;
        logic [7:0] hour_raw;
        logic [7:0] minute_raw;
        logic [7:0] ms_hi;
        logic [7:0] ms_lo;
    } frame_rec_t;

endpackage

// ===== sv/time_sync_frame_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_sync_frame_parser_top
// parses time-sync packets byte by byte and reports status and date/time
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      data_byte[7:0], last_byte
//  result    empty / pop      status[1:0], year[11:0], month[3:0], day[4:0],
//                             hour[4:0], minute[5:0], second[5:0]
//
//  one byte beat is taken every cycle while full is low; a result shows once
//  its record has passed intake to record queue and queue to result register
//  the record queue and the result register decouple the sides, so a held
//  pop stalls input only once the queue is full as well
//  asynchronous reset empties the queue and restarts the byte count
// ----------------------------------------------------------------------------
module time_sync_frame_parser_top
    import tsfp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = TSFP_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    // record handoff between intake and decode
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    frame_rec_t wr_rec;
    frame_rec_t rd_rec;

    // intake: counts beats, keeps bytes, builds a record on the last beat
    tsfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_push    (q_push),
        .q_rec     (wr_rec),
        .q_full    (q_full)
    );

    // short queue so intake keeps going while a result waits
    tsfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (wr_rec),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (rd_rec),
        .q_empty (q_empty)
    );

    // decode: field checks, ms to seconds, status priority, result register
    tsfp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rec   (rd_rec),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .status  (status),
        .year    (year),
        .month   (month),
        .day     (day),
        .hour    (hour),
        .minute  (minute),
        .second  (second)
    );

endmodule

// ===== sv/tsfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfp_front
// byte intake: counts beats, keeps payload bytes, judges the header
// ----------------------------------------------------------------------------
module tsfp_front
    import tsfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       q_push,
    output frame_rec_t q_rec,
    input  logic       q_full
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               hdr_bad_reg;
    logic               hdr_bad_next;
    logic [7:0]         frame_reg [STORE_N];
    logic [7:0]         cur [STORE_N];
    logic               accept;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept && last_byte;

    always_comb
    begin
        hdr_bad_next = hdr_bad_reg;
        if (count_reg == COUNT_W'(0) && data_byte != HDR_SYNC)
        begin
            hdr_bad_next = 1'b1;
        end
        if (count_reg == COUNT_W'(1) && data_byte != HDR_ID)
        begin
            hdr_bad_next = 1'b1;
        end
        if (count_reg >= COUNT_W'(COUNT_MAX - 1))
        begin
            count_next = COUNT_W'(COUNT_MAX);
        end
        else
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    // current beat bypasses the store so the record sees the final byte
    always_comb
    begin
        for (int k = 0; k < STORE_N; k++)
        begin
            cur[k] = (count_reg == COUNT_W'(k + STORE_LO)) ? data_byte : frame_reg[k];
        end
    end

    always_comb
    begin
        q_rec.hdr_bad    = hdr_bad_next;
        q_rec.len_ok     = (count_next == COUNT_W'(FRAME_LEN));
        q_rec.ms_lo      = cur[0];
        q_rec.ms_hi      = cur[1];
        q_rec.minute_raw = cur[2];
        q_rec.hour_raw   = cur[3];
        q_rec.day_raw    = cur[4];
        q_rec.month_raw  = cur[5];
        q_rec.year_raw   = cur[6];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            hdr_bad_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg   <= '0;
                hdr_bad_reg <= 1'b0;
            end
            else
            begin
                count_reg   <= count_next;
                hdr_bad_reg <= hdr_bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STORE_N; k++)
        begin
            if (accept && count_reg == COUNT_W'(k + STORE_LO))
            begin
                frame_reg[k] <= data_byte;
            end
        end
    end

endmodule

// ===== sv/tsfp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfp_queue
// short record queue between intake and decode
// ----------------------------------------------------------------------------
module tsfp_queue
    import tsfp_pkg::*;
#(
    parameter int unsigned DEPTH = TSFP_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  frame_rec_t wr_data,
    output logic       q_full,
    input  logic       rd_en,
    output frame_rec_t rd_data,
    output logic       q_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    frame_rec_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/tsfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfp_back
// record decode: range checks, seconds, status, result register
// ----------------------------------------------------------------------------
module tsfp_back
    import tsfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  frame_rec_t  q_rec,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    logic        valid_reg;
    status_t     status_reg;
    status_t     status_next;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [15:0] ms;
    logic [32:0] prod;
    logic [6:0]  sec_full;
    logic        field_bad;
    logic        ok;

    assign q_pop = !q_empty && (!valid_reg || pop);
    assign empty = !valid_reg;

    assign ms       = {q_rec.ms_hi, q_rec.ms_lo};
    assign prod     = 33'(ms) * 33'(MS_RECIP);
    assign sec_full = prod[32:MS_SHIFT];

    always_comb
    begin
        field_bad = (q_rec.year_raw >= YEAR_SPAN)
                 || (q_rec.month_raw == 8'd0) || (q_rec.month_raw >= MONTH_END)
                 || (q_rec.day_raw == 8'd0) || (q_rec.day_raw >= DAY_END)
                 || (q_rec.hour_raw >= HOUR_END)
                 || (q_rec.minute_raw >= MINUTE_END)
                 || (ms >= MS_LIMIT);
        if (q_rec.hdr_bad)
        begin
            status_next = ST_BAD_HEADER;
        end
        else if (!q_rec.len_ok)
        begin
            status_next = ST_BAD_LENGTH;
        end
        else if (field_bad)
        begin
            status_next = ST_BAD_FIELD;
        end
        else
        begin
            status_next = ST_ACCEPTED;
        end
        ok = (status_next == ST_ACCEPTED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= status_next;
            year_reg   <= ok ? YEAR_BASE + 12'(q_rec.year_raw) : '0;
            month_reg  <= ok ? q_rec.month_raw[3:0] : '0;
            day_reg    <= ok ? q_rec.day_raw[4:0] : '0;
            hour_reg   <= ok ? q_rec.hour_raw[4:0] : '0;
            minute_reg <= ok ? q_rec.minute_raw[5:0] : '0;
            second_reg <= ok ? sec_full[5:0] : '0;
        end
    end

    assign status = status_reg;
    assign year   = year_reg;
    assign month  = month_reg;
    assign day    = day_reg;
    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = second_reg;

endmodule

// ===== sv/tsfp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfp_checker
// port-level checks of the time-sync frame parser
// ----------------------------------------------------------------------------
module tsfp_checker
    import tsfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  status,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second
);

    // rejected frames carry no date
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_ACCEPTED) |->
        (year == '0 && month == '0 && day == '0 && hour == '0 && minute == '0
         && second == '0))
        else $error("rejected frame with nonzero date fields");

    // accepted frames carry an in-range date
    a_accept_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_ACCEPTED) |->
        (year >= 12'd2000 && year <= 12'd2099 && month >= 4'd1 && month <= 4'd12
         && day >= 5'd1 && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
        else $error("accepted frame with out-of-range date");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(year)
                              && $stable(second)))
        else $error("result changed while stalled");

    // reset leaves both sides idle by the next edge
    a_reset: assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("not idle in reset");

endmodule

bind time_sync_frame_parser_top tsfp_checker u_tsfp_checker (.*);
